/* design/planar_motion_predict_core_macros.svh */
// ----------------------------------------------------------------------------
// planar motion predict assertion macros
// shared concurrent assertion forms, clocked on clk with asynchronous reset
// ----------------------------------------------------------------------------
`ifndef PLANAR_MOTION_PREDICT_CORE_MACROS_SVH
`define PLANAR_MOTION_PREDICT_CORE_MACROS_SVH

// same-cycle implication
`define PMP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmp assertion failed");

// next-cycle implication
`define PMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmp assertion failed");

`endif

/* design/pmp_pkg.sv */
// ----------------------------------------------------------------------------
// pmp_pkg
// constants, stage types and helpers of the planar motion predictor
// ----------------------------------------------------------------------------
package pmp_pkg;

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [15:0] PI_Q13      = 16'sd25736;
    localparam logic [16:0]        TWO_PI_Q13  = 17'd51472;
    // multiple of two pi that keeps the wrap operand non-negative
    localparam logic [31:0]        WRAP_OFFSET = 32'd1686634496;
    localparam logic [32:0]        WRAP_RECIP  = 33'((64'd1 << 48) / 64'd51472);
    localparam int                 WRAP_SHIFT  = 48;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [15:0] hd;
        logic [15:0]        dt;
        logic [31:0]        dt2;
        logic signed [48:0] dt_ax;
        logic signed [48:0] dt_ay;
        logic signed [48:0] dt_yr;
        logic               flip;
    } carry_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [15:0]        dt;
        logic [31:0]        dt2;
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        hv;
        logic [16:0]        q;
        logic [16:0]        r;
        logic signed [15:0] hd;
        logic signed [48:0] p1c;
        logic signed [48:0] p1s;
        logic signed [64:0] p2c;
        logic signed [64:0] p2s;
        logic signed [31:0] fc;
        logic signed [31:0] fs;
        logic signed [31:0] hc;
        logic signed [31:0] hs;
        logic signed [31:0] jdc;
        logic signed [31:0] jds;
        logic signed [31:0] jhc;
        logic signed [31:0] jhs;
        logic signed [63:0] m_vx_c;
        logic signed [63:0] m_vx_s;
        logic signed [63:0] m_vy_c;
        logic signed [63:0] m_vy_s;
        logic signed [63:0] m_ax_c;
        logic signed [63:0] m_ax_s;
        logic signed [63:0] m_ay_c;
        logic signed [63:0] m_ay_s;
        logic signed [35:0] dx;
        logic signed [35:0] dy;
    } post_t;

    typedef struct packed {
        logic signed [31:0] next_pos_x;
        logic signed [31:0] next_pos_y;
        logic signed [31:0] next_vel_x;
        logic signed [31:0] next_vel_y;
        logic signed [15:0] next_heading;
        logic signed [31:0] jac_dt_cos;
        logic signed [31:0] jac_dt_sin;
        logic signed [31:0] jac_half_dt2_cos;
        logic signed [31:0] jac_half_dt2_sin;
        logic signed [31:0] jac_x_heading;
        logic signed [31:0] jac_y_heading;
    } result_t;

    function automatic logic signed [33:0] atan_q30(input int unsigned idx);
        logic signed [33:0] v;
        case (idx)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] o;
        if (v > 37'sd2147483647)
            o = 32'sh7fff_ffff;
        else if (v < -37'sd2147483648)
            o = 32'sh8000_0000;
        else
            o = v[31:0];
        return o;
    endfunction

endpackage

/* design/pmp_ifs.sv */
// ----------------------------------------------------------------------------
// pmp item channels
// valid/ready channels for the input state and the predicted result
// ----------------------------------------------------------------------------
interface pmp_state_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [15:0] heading;
    logic signed [31:0] yaw_rate;
    logic [15:0]        step_time;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, heading,
                    yaw_rate, step_time, input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, heading,
                  yaw_rate, step_time, output ready);
endinterface

interface pmp_pred_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] next_pos_x;
    logic signed [31:0] next_pos_y;
    logic signed [31:0] next_vel_x;
    logic signed [31:0] next_vel_y;
    logic signed [15:0] next_heading;
    logic signed [31:0] jac_dt_cos;
    logic signed [31:0] jac_dt_sin;
    logic signed [31:0] jac_half_dt2_cos;
    logic signed [31:0] jac_half_dt2_sin;
    logic signed [31:0] jac_x_heading;
    logic signed [31:0] jac_y_heading;

    modport source (output valid, next_pos_x, next_pos_y, next_vel_x, next_vel_y,
                    next_heading, jac_dt_cos, jac_dt_sin, jac_half_dt2_cos,
                    jac_half_dt2_sin, jac_x_heading, jac_y_heading, input ready);
    modport sink (input valid, next_pos_x, next_pos_y, next_vel_x, next_vel_y,
                  next_heading, jac_dt_cos, jac_dt_sin, jac_half_dt2_cos,
                  jac_half_dt2_sin, jac_x_heading, jac_y_heading, output ready);
endinterface

/* design/planar_motion_predict_core.sv */
// ----------------------------------------------------------------------------
// planar_motion_predict_core
// constant-acceleration planar state prediction with cordic heading rotation
// ----------------------------------------------------------------------------
// One item enters per clock and its result passes through one input stage,
// one cordic stage per rotation step and seven stages of multiply, round,
// wrap and saturate. The whole pipeline holds while a finished result waits
// at the output, so throughput is one item per cycle whenever the output is
// taken. jacobian_enable resets to 1 and takes effect as each result is
// formed.
`include "planar_motion_predict_core_macros.svh"

module planar_motion_predict_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    pmp_state_if.sink         state_in,
    pmp_pred_if.source        pred_out
);

    localparam int N     = CORDIC_STAGES;
    localparam int DEPTH = N + 8;
    localparam int ST_A  = N + 1;
    localparam int ST_C  = N + 3;
    localparam int ST_G  = N + 7;

    logic                jac_en_reg;
    logic [DEPTH-1:0]    vld_reg;
    logic                adv;
    logic                trig_ok;
    logic                heading_ok;

    logic signed [33:0]  x_reg   [0:N];
    logic signed [33:0]  y_reg   [0:N];
    logic signed [33:0]  ang_reg [0:N];
    pmp_pkg::carry_t     carry_reg [0:N];
    logic signed [33:0]  x_next   [0:N];
    logic signed [33:0]  y_next   [0:N];
    logic signed [33:0]  ang_next [0:N];
    pmp_pkg::carry_t     carry_next [0:N];

    pmp_pkg::post_t      pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    pmp_pkg::post_t      pa_next, pb_next, pc_next, pd_next, pe_next, pf_next;
    pmp_pkg::result_t    res_reg, res_next;

    assign adv            = !vld_reg[ST_G] || pred_out.ready;
    assign state_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jac_en_reg <= 1'b1;
            vld_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                jac_en_reg <= cfg_wr_data;
            if (adv)
                vld_reg <= {vld_reg[DEPTH-2:0], state_in.valid};
        end
    end

    // input stage: angle fold and the multiplies that need no trig
    always_comb
    begin
        logic signed [33:0] a;
        a = $signed({state_in.heading[15], state_in.heading, 17'b0});
        carry_next[0].flip = 1'b0;
        if (a > pmp_pkg::HALF_PI_Q30)
        begin
            a = a - pmp_pkg::PI_Q30;
            carry_next[0].flip = 1'b1;
        end
        else if (a < -pmp_pkg::HALF_PI_Q30)
        begin
            a = a + pmp_pkg::PI_Q30;
            carry_next[0].flip = 1'b1;
        end
        ang_next[0] = a;
        x_next[0]   = pmp_pkg::GAIN_Q30;
        y_next[0]   = '0;
        carry_next[0].px    = state_in.pos_x;
        carry_next[0].py    = state_in.pos_y;
        carry_next[0].vx    = state_in.vel_x;
        carry_next[0].vy    = state_in.vel_y;
        carry_next[0].ax    = state_in.acc_x;
        carry_next[0].ay    = state_in.acc_y;
        carry_next[0].hd    = state_in.heading;
        carry_next[0].dt    = state_in.step_time;
        carry_next[0].dt2   = 32'(state_in.step_time) * 32'(state_in.step_time);
        carry_next[0].dt_ax = $signed({1'b0, state_in.step_time}) * state_in.acc_x;
        carry_next[0].dt_ay = $signed({1'b0, state_in.step_time}) * state_in.acc_y;
        carry_next[0].dt_yr = $signed({1'b0, state_in.step_time}) * state_in.yaw_rate;

        // cordic rotation steps
        for (int k = 0; k < N; k++)
        begin
            if (ang_reg[k] >= 0)
            begin
                x_next[k+1]   = x_reg[k] - (y_reg[k] >>> k);
                y_next[k+1]   = y_reg[k] + (x_reg[k] >>> k);
                ang_next[k+1] = ang_reg[k] - pmp_pkg::atan_q30(k);
            end
            else
            begin
                x_next[k+1]   = x_reg[k] + (y_reg[k] >>> k);
                y_next[k+1]   = y_reg[k] - (x_reg[k] >>> k);
                ang_next[k+1] = ang_reg[k] + pmp_pkg::atan_q30(k);
            end
            carry_next[k+1] = carry_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= N; k++)
            begin
                x_reg[k]     <= x_next[k];
                y_reg[k]     <= y_next[k];
                ang_reg[k]   <= ang_next[k];
                carry_reg[k] <= carry_next[k];
            end
        end
    end

    // stage a: unfold and clamp, velocity update, heading wrap operand
    always_comb
    begin
        logic signed [33:0] xf, yf, vx_sum, vy_sum, nh;
        pa_next = pa_reg;
        xf = carry_reg[N].flip ? -x_reg[N] : x_reg[N];
        yf = carry_reg[N].flip ? -y_reg[N] : y_reg[N];
        if (xf > pmp_pkg::ONE_Q30)
            xf = pmp_pkg::ONE_Q30;
        else if (xf < -pmp_pkg::ONE_Q30)
            xf = -pmp_pkg::ONE_Q30;
        if (yf > pmp_pkg::ONE_Q30)
            yf = pmp_pkg::ONE_Q30;
        else if (yf < -pmp_pkg::ONE_Q30)
            yf = -pmp_pkg::ONE_Q30;
        pa_next.c   = xf[31:0];
        pa_next.s   = yf[31:0];
        pa_next.px  = carry_reg[N].px;
        pa_next.py  = carry_reg[N].py;
        pa_next.vx  = carry_reg[N].vx;
        pa_next.vy  = carry_reg[N].vy;
        pa_next.ax  = carry_reg[N].ax;
        pa_next.ay  = carry_reg[N].ay;
        pa_next.dt  = carry_reg[N].dt;
        pa_next.dt2 = carry_reg[N].dt2;
        vx_sum = 34'(carry_reg[N].vx) + 34'((carry_reg[N].dt_ax + 49'sh8000) >>> 16);
        vy_sum = 34'(carry_reg[N].vy) + 34'((carry_reg[N].dt_ay + 49'sh8000) >>> 16);
        pa_next.vel_x = pmp_pkg::sat32(37'(vx_sum));
        pa_next.vel_y = pmp_pkg::sat32(37'(vy_sum));
        nh = 34'(carry_reg[N].hd) + 34'((carry_reg[N].dt_yr + 49'sh4_0000) >>> 19);
        pa_next.hv = 32'(nh + 34'(pmp_pkg::PI_Q13) + 34'(pmp_pkg::WRAP_OFFSET));
    end

    // stage b: trig factor products, wrap quotient estimate
    always_comb
    begin
        logic [64:0] qprod;
        pb_next = pa_reg;
        pb_next.p1c = $signed({1'b0, pa_reg.dt}) * pa_reg.c;
        pb_next.p1s = $signed({1'b0, pa_reg.dt}) * pa_reg.s;
        pb_next.p2c = $signed({1'b0, pa_reg.dt2}) * pa_reg.c;
        pb_next.p2s = $signed({1'b0, pa_reg.dt2}) * pa_reg.s;
        qprod = 65'(pa_reg.hv) * 65'(pmp_pkg::WRAP_RECIP);
        pb_next.q = qprod[pmp_pkg::WRAP_SHIFT+16:pmp_pkg::WRAP_SHIFT];
    end

    // stage c: round factors, wrap remainder
    always_comb
    begin
        pc_next = pb_reg;
        pc_next.fc  = 32'((pb_reg.p1c + 49'sh8000) >>> 16);
        pc_next.fs  = 32'((pb_reg.p1s + 49'sh8000) >>> 16);
        pc_next.jdc = 32'((pb_reg.p1c + 49'sh2000_0000) >>> 30);
        pc_next.jds = 32'((pb_reg.p1s + 49'sh2000_0000) >>> 30);
        pc_next.hc  = 32'((pb_reg.p2c + 65'sh1_0000_0000) >>> 33);
        pc_next.hs  = 32'((pb_reg.p2s + 65'sh1_0000_0000) >>> 33);
        pc_next.jhc = 32'((pb_reg.p2c + 65'sh4000_0000_0000) >>> 47);
        pc_next.jhs = 32'((pb_reg.p2s + 65'sh4000_0000_0000) >>> 47);
        pc_next.r   = 17'(pb_reg.hv - 32'(pb_reg.q) * 32'(pmp_pkg::TWO_PI_Q13));
    end

    // stage d: rotation products, final heading
    always_comb
    begin
        logic [16:0] rc;
        pd_next = pc_reg;
        pd_next.m_vx_c = pc_reg.vx * pc_reg.fc;
        pd_next.m_vx_s = pc_reg.vx * pc_reg.fs;
        pd_next.m_vy_c = pc_reg.vy * pc_reg.fc;
        pd_next.m_vy_s = pc_reg.vy * pc_reg.fs;
        pd_next.m_ax_c = pc_reg.ax * pc_reg.hc;
        pd_next.m_ax_s = pc_reg.ax * pc_reg.hs;
        pd_next.m_ay_c = pc_reg.ay * pc_reg.hc;
        pd_next.m_ay_s = pc_reg.ay * pc_reg.hs;
        rc = (pc_reg.r >= pmp_pkg::TWO_PI_Q13) ? pc_reg.r - pmp_pkg::TWO_PI_Q13 : pc_reg.r;
        pd_next.hd = 16'($signed({1'b0, rc}) - 18'(pmp_pkg::PI_Q13));
    end

    // stage e: round each product to q16.16
    always_comb
    begin
        pe_next = pd_reg;
        pe_next.m_vx_c = (pd_reg.m_vx_c + 64'sh2000_0000) >>> 30;
        pe_next.m_vx_s = (pd_reg.m_vx_s + 64'sh2000_0000) >>> 30;
        pe_next.m_vy_c = (pd_reg.m_vy_c + 64'sh2000_0000) >>> 30;
        pe_next.m_vy_s = (pd_reg.m_vy_s + 64'sh2000_0000) >>> 30;
        pe_next.m_ax_c = (pd_reg.m_ax_c + 64'sh2000_0000) >>> 30;
        pe_next.m_ax_s = (pd_reg.m_ax_s + 64'sh2000_0000) >>> 30;
        pe_next.m_ay_c = (pd_reg.m_ay_c + 64'sh2000_0000) >>> 30;
        pe_next.m_ay_s = (pd_reg.m_ay_s + 64'sh2000_0000) >>> 30;
    end

    // stage f: world-frame displacement
    always_comb
    begin
        pf_next = pe_reg;
        pf_next.dx = 36'(pe_reg.m_vx_c) + 36'(pe_reg.m_ax_c)
                   - 36'(pe_reg.m_vy_s) - 36'(pe_reg.m_ay_s);
        pf_next.dy = 36'(pe_reg.m_vx_s) + 36'(pe_reg.m_ax_s)
                   + 36'(pe_reg.m_vy_c) + 36'(pe_reg.m_ay_c);
    end

    // stage g: saturate and gate the jacobian
    always_comb
    begin
        res_next.next_pos_x   = pmp_pkg::sat32(37'(pf_reg.px) + 37'(pf_reg.dx));
        res_next.next_pos_y   = pmp_pkg::sat32(37'(pf_reg.py) + 37'(pf_reg.dy));
        res_next.next_vel_x   = pf_reg.vel_x;
        res_next.next_vel_y   = pf_reg.vel_y;
        res_next.next_heading = pf_reg.hd;
        if (jac_en_reg)
        begin
            res_next.jac_dt_cos       = pf_reg.jdc;
            res_next.jac_dt_sin       = pf_reg.jds;
            res_next.jac_half_dt2_cos = pf_reg.jhc;
            res_next.jac_half_dt2_sin = pf_reg.jhs;
            res_next.jac_x_heading    = pmp_pkg::sat32(-37'(pf_reg.dy));
            res_next.jac_y_heading    = pmp_pkg::sat32(37'(pf_reg.dx));
        end
        else
        begin
            res_next.jac_dt_cos       = '0;
            res_next.jac_dt_sin       = '0;
            res_next.jac_half_dt2_cos = '0;
            res_next.jac_half_dt2_sin = '0;
            res_next.jac_x_heading    = '0;
            res_next.jac_y_heading    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            pc_reg  <= pc_next;
            pd_reg  <= pd_next;
            pe_reg  <= pe_next;
            pf_reg  <= pf_next;
            res_reg <= res_next;
        end
    end

    assign pred_out.valid            = vld_reg[ST_G];
    assign pred_out.next_pos_x       = res_reg.next_pos_x;
    assign pred_out.next_pos_y       = res_reg.next_pos_y;
    assign pred_out.next_vel_x       = res_reg.next_vel_x;
    assign pred_out.next_vel_y       = res_reg.next_vel_y;
    assign pred_out.next_heading     = res_reg.next_heading;
    assign pred_out.jac_dt_cos       = res_reg.jac_dt_cos;
    assign pred_out.jac_dt_sin       = res_reg.jac_dt_sin;
    assign pred_out.jac_half_dt2_cos = res_reg.jac_half_dt2_cos;
    assign pred_out.jac_half_dt2_sin = res_reg.jac_half_dt2_sin;
    assign pred_out.jac_x_heading    = res_reg.jac_x_heading;
    assign pred_out.jac_y_heading    = res_reg.jac_y_heading;

    assign trig_ok = (34'(pa_reg.c) <= pmp_pkg::ONE_Q30) && (34'(pa_reg.c) >= -pmp_pkg::ONE_Q30)
                  && (34'(pa_reg.s) <= pmp_pkg::ONE_Q30) && (34'(pa_reg.s) >= -pmp_pkg::ONE_Q30);
    assign heading_ok = (pred_out.next_heading >= -pmp_pkg::PI_Q13)
                     && (pred_out.next_heading < pmp_pkg::PI_Q13);

    `PMP_ASSERT_NEXT(a_accept_enters, state_in.valid && state_in.ready, vld_reg[0])
    `PMP_ASSERT_IMPLY(a_trig_clamped, vld_reg[ST_A], trig_ok)
    `PMP_ASSERT_IMPLY(a_wrap_one_fix, vld_reg[ST_C], pc_reg.r < 17'd102944)
    `PMP_ASSERT_IMPLY(a_heading_range, pred_out.valid, heading_ok)

endmodule
